/* sv/tlfq_pkg.sv */
// ----------------------------------------------------------------------------
// Three-level feedback queue scheduler package
// Shared types, register indexes and field widths of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlfq_pkg;

  // Field widths
  localparam int unsigned NameW  = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned TimeW  = 22;
  localparam int unsigned QuantW = 8;
  localparam int unsigned BudW   = 16;
  localparam int unsigned LevelW = 2;

  // Configuration register indexes
  localparam logic [2:0] RegQuantumOne = 3'd0;
  localparam logic [2:0] RegQuantumTwo = 3'd1;
  localparam logic [2:0] RegBudgetOne  = 3'd2;
  localparam logic [2:0] RegBudgetTwo  = 3'd3;
  localparam logic [2:0] RegBudgetThree = 3'd4;

  // Level codes; the last one holds the jobs reported as uncompleted
  localparam logic [1:0] LvlOne    = 2'd0;
  localparam logic [1:0] LvlTwo    = 2'd1;
  localparam logic [1:0] LvlThree  = 2'd2;
  localparam logic [1:0] LvlUncomp = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POP,
    ST_JRD,
    ST_EXEC
  } state_e;

  // What the execution unit decided for the current job
  typedef enum logic [2:0] {
    ACT_DONE,
    ACT_DOWN,
    ACT_REQUEUE,
    ACT_UNCOMP,
    ACT_REPORT
  } act_e;

  // One entry of the job table
  typedef struct packed {
    logic [NameW-1:0]  name;
    logic [BurstW-1:0] burst;
    logic [BurstW-1:0] rem;
    logic [TimeW-1:0]  first;
    logic              started;
  } job_t;

  // Decision of the execution unit
  typedef struct packed {
    act_e              act;
    logic              touch;
    logic [BurstW-1:0] delta;
  } exec_t;

endpackage

`default_nettype wire

/* sv/tlfq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output      logic [WIDTH-1:0]                              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/tlfq_exec.sv */
// ----------------------------------------------------------------------------
// Scheduler execution unit
// Decides the fate of one job slice: how much time it runs and where it goes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlfq_exec (
  input  wire logic [1:0]                  lvl_i,
  input  wire logic [tlfq_pkg::BurstW-1:0] rem_i,
  input  wire logic [tlfq_pkg::TimeW-1:0]  level_time_i,
  input  wire logic [tlfq_pkg::BurstW-1:0] quantum_i,
  input  wire logic [tlfq_pkg::BudW-1:0]   budget_i,
  output      tlfq_pkg::exec_t             res_o
);
  logic [tlfq_pkg::TimeW-1:0] budget_ext;
  logic [tlfq_pkg::TimeW-1:0] lt_plus_rem;
  logic                       fits_q;

  assign budget_ext  = tlfq_pkg::TimeW'(budget_i);
  assign lt_plus_rem = level_time_i + tlfq_pkg::TimeW'(rem_i);
  assign fits_q      = (rem_i <= quantum_i);

  // Slice decision for the current level
  always_comb begin
    res_o.act   = tlfq_pkg::ACT_REPORT;
    res_o.touch = 1'b0;
    res_o.delta = '0;
    case (lvl_i)
      tlfq_pkg::LvlUncomp: begin
        res_o.act = tlfq_pkg::ACT_REPORT;
      end
      tlfq_pkg::LvlThree: begin
        if (level_time_i > budget_ext) begin
          res_o.act = tlfq_pkg::ACT_UNCOMP;
        end else begin
          res_o.act   = tlfq_pkg::ACT_DONE;
          res_o.touch = 1'b1;
          res_o.delta = rem_i;
        end
      end
      default: begin
        if (level_time_i >= budget_ext) begin
          res_o.act = tlfq_pkg::ACT_DOWN;
        end else if (fits_q && (lt_plus_rem <= budget_ext)) begin
          res_o.act   = tlfq_pkg::ACT_DONE;
          res_o.touch = 1'b1;
          res_o.delta = rem_i;
        end else if (fits_q) begin
          // Short job that overruns the budget: run to the budget, then drop.
          res_o.act   = tlfq_pkg::ACT_DOWN;
          res_o.touch = 1'b1;
          res_o.delta = budget_i - level_time_i[tlfq_pkg::BudW-1:0];
        end else begin
          res_o.act   = tlfq_pkg::ACT_REQUEUE;
          res_o.touch = 1'b1;
          res_o.delta = quantum_i;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/three_level_feedback_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// Three-level feedback queue scheduler
// Loads a batch of jobs, simulates three feedback levels and reports each job.
// ----------------------------------------------------------------------------
// Usage: jobs enter on the s_axis channel, one transaction per cycle while
// loading; tlast marks the final job and starts the simulation. Results leave
// on the m_axis channel in completion order, uncompleted jobs last, with tlast
// on the final result. Registers are written on the cfg channel, which is
// always ready; the user must write them only while the block is idle, which
// the block itself does not enforce. Every slice of a job passes through three
// sequencer steps (queue read, job table read, execute), since queue and job
// table are RAMs with registered reads. s_axis is not ready while a batch runs.
// When the receiver stalls, the output register holds its result and the
// sequencer waits in its execute step. Reset clears the control state and
// restores the register defaults; the RAMs need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_level_feedback_queue_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: proc_name[7:0], burst_time[23:8]
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tlast: is_last
  input  wire logic        s_axis_tlast,
  // tdata: out_name[7:0], finish_level[9:8], turnaround[31:10],
  //        waiting[53:32], first_run[75:54], zero fill[79:76]
  output      logic [79:0] m_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tlast: last_result
  output      logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned PtrW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CntW   = PtrW + 1;
  localparam int unsigned JDepth = 1 << PtrW;
  localparam int unsigned QDepth = 4 << PtrW;
  localparam int unsigned JobW   = $bits(tlfq_pkg::job_t);
  localparam int unsigned TW     = tlfq_pkg::TimeW;

  // Configuration registers
  logic [7:0]  quantum_one_q, quantum_two_q;
  logic [15:0] budget_one_q, budget_two_q, budget_three_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_one_q  <= 8'd2;
      quantum_two_q  <= 8'd4;
      budget_one_q   <= 16'd8;
      budget_two_q   <= 16'd16;
      budget_three_q <= 16'd32;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tlfq_pkg::RegQuantumOne:  quantum_one_q  <= cfg_data_i[7:0];
        tlfq_pkg::RegQuantumTwo:  quantum_two_q  <= cfg_data_i[7:0];
        tlfq_pkg::RegBudgetOne:   budget_one_q   <= cfg_data_i;
        tlfq_pkg::RegBudgetTwo:   budget_two_q   <= cfg_data_i;
        tlfq_pkg::RegBudgetThree: budget_three_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and scheduling state
  tlfq_pkg::state_e state_q, state_d;
  logic [1:0]      lvl_q, lvl_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic [PtrW-1:0] cur_head_q, cur_head_d;
  logic [CntW-1:0] cur_len_q, cur_len_d;
  logic [CntW-1:0] nxt_len_q, nxt_len_d;
  logic [TW-1:0]   gt_q, gt_d;
  logic [TW-1:0]   lt_q, lt_d;
  logic [PtrW-1:0] job_q, job_d;

  // Output register
  logic        ovalid_q, ovalid_d;
  logic        olast_q, olast_d;
  logic [79:0] odata_q, odata_d;

  // RAM ports
  logic                 j_we, j_re, q_we, q_re;
  logic [PtrW-1:0]      j_waddr, j_raddr;
  logic [PtrW+1:0]      q_waddr, q_raddr;
  tlfq_pkg::job_t       j_wdata, j_rdata;
  logic [PtrW-1:0]      q_wdata, q_rdata;
  logic [JobW-1:0]      j_rdata_raw;

  assign j_rdata = tlfq_pkg::job_t'(j_rdata_raw);

  tlfq_ram #(.WIDTH(JobW), .DEPTH(JDepth)) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (j_we),
    .waddr_i (j_waddr),
    .wdata_i (JobW'(j_wdata)),
    .re_i    (j_re),
    .raddr_i (j_raddr),
    .rdata_o (j_rdata_raw)
  );

  tlfq_ram #(.WIDTH(PtrW), .DEPTH(QDepth)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Shared execution unit
  logic [15:0]     quantum_eff;
  logic [15:0]     budget_sel;
  tlfq_pkg::exec_t ex;

  always_comb begin
    if (lvl_q == tlfq_pkg::LvlOne) begin
      quantum_eff = (quantum_one_q == 8'd0) ? 16'd1 : 16'(quantum_one_q);
      budget_sel  = budget_one_q;
    end else if (lvl_q == tlfq_pkg::LvlTwo) begin
      quantum_eff = (quantum_two_q == 8'd0) ? 16'd1 : 16'(quantum_two_q);
      budget_sel  = budget_two_q;
    end else begin
      quantum_eff = 16'd1;
      budget_sel  = budget_three_q;
    end
  end

  tlfq_exec u_exec (
    .lvl_i        (lvl_q),
    .rem_i        (j_rdata.rem),
    .level_time_i (lt_q),
    .quantum_i    (quantum_eff),
    .budget_i     (budget_sel),
    .res_o        (ex)
  );

  logic            in_acc, out_free, emit, stall;
  logic [CntW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic [TW-1:0]   gt_new;
  logic            started_new;
  logic [TW-1:0]   first_new;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign emit     = (ex.act == tlfq_pkg::ACT_DONE) || (ex.act == tlfq_pkg::ACT_REPORT);
  assign stall    = emit && !out_free;
  assign tail_sum = CntW'(cur_head_q) + cur_len_q;
  assign tail     = (tail_sum >= CntW'(MAX_JOBS)) ?
                    PtrW'(tail_sum - CntW'(MAX_JOBS)) : PtrW'(tail_sum);
  assign gt_new   = gt_q + TW'(ex.delta);
  assign started_new = j_rdata.started || ex.touch;
  assign first_new   = j_rdata.started ? j_rdata.first : (ex.touch ? gt_q : j_rdata.first);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlfq_pkg::ST_LOAD: begin
        if (in_acc && s_axis_tlast) state_d = tlfq_pkg::ST_POP;
      end
      tlfq_pkg::ST_POP: begin
        if (cur_len_q != '0) begin
          state_d = tlfq_pkg::ST_JRD;
        end else if (lvl_q == tlfq_pkg::LvlUncomp) begin
          state_d = tlfq_pkg::ST_LOAD;
        end
      end
      tlfq_pkg::ST_JRD:  state_d = tlfq_pkg::ST_EXEC;
      tlfq_pkg::ST_EXEC: begin
        if (!stall) state_d = tlfq_pkg::ST_POP;
      end
      default: state_d = tlfq_pkg::ST_LOAD;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    lvl_d      = lvl_q;
    count_d    = count_q;
    emitted_d  = emitted_q;
    cur_head_d = cur_head_q;
    cur_len_d  = cur_len_q;
    nxt_len_d  = nxt_len_q;
    gt_d       = gt_q;
    lt_d       = lt_q;
    job_d      = job_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    olast_d    = olast_q;
    odata_d    = odata_q;
    j_we = 1'b0; j_re = 1'b0; q_we = 1'b0; q_re = 1'b0;
    j_waddr = job_q;
    j_raddr = job_q;
    j_wdata = j_rdata;
    q_waddr = {tlfq_pkg::LvlOne, count_q[PtrW-1:0]};
    q_raddr = {lvl_q, cur_head_q};
    q_wdata = count_q[PtrW-1:0];
    s_axis_tready = 1'b0;
    case (state_q)
      tlfq_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        j_waddr = count_q[PtrW-1:0];
        j_wdata.name    = s_axis_tdata[7:0];
        j_wdata.burst   = s_axis_tdata[23:8];
        j_wdata.rem     = s_axis_tdata[23:8];
        j_wdata.first   = '0;
        j_wdata.started = 1'b0;
        if (in_acc) begin
          if (count_q < CntW'(MAX_JOBS)) begin
            j_we    = 1'b1;
            q_we    = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (s_axis_tlast) begin
            lvl_d      = tlfq_pkg::LvlOne;
            cur_head_d = '0;
            cur_len_d  = (count_q < CntW'(MAX_JOBS)) ? count_q + 1'b1 : count_q;
            nxt_len_d  = '0;
            gt_d       = '0;
            lt_d       = '0;
            emitted_d  = '0;
          end
        end
      end
      tlfq_pkg::ST_POP: begin
        if (cur_len_q != '0) begin
          q_re       = 1'b1;
          cur_len_d  = cur_len_q - 1'b1;
          cur_head_d = (cur_head_q == PtrW'(MAX_JOBS - 1)) ? '0 : cur_head_q + 1'b1;
        end else if (lvl_q == tlfq_pkg::LvlUncomp) begin
          count_d = '0;
          gt_d    = '0;
          lt_d    = '0;
        end else begin
          // Level exhausted: the next level's queue becomes current.
          lvl_d      = lvl_q + 1'b1;
          cur_head_d = '0;
          cur_len_d  = nxt_len_q;
          nxt_len_d  = '0;
          lt_d       = '0;
        end
      end
      tlfq_pkg::ST_JRD: begin
        job_d   = q_rdata;
        j_re    = 1'b1;
        j_raddr = q_rdata;
      end
      tlfq_pkg::ST_EXEC: begin
        if (!stall) begin
          j_we            = 1'b1;
          j_wdata.rem     = j_rdata.rem - ex.delta;
          j_wdata.started = started_new;
          j_wdata.first   = first_new;
          gt_d = gt_new;
          lt_d = lt_q + TW'(ex.delta);
          q_wdata = job_q;
          case (ex.act)
            tlfq_pkg::ACT_REQUEUE: begin
              q_we      = 1'b1;
              q_waddr   = {lvl_q, tail};
              cur_len_d = cur_len_q + 1'b1;
            end
            tlfq_pkg::ACT_DOWN, tlfq_pkg::ACT_UNCOMP: begin
              q_we      = 1'b1;
              q_waddr   = {lvl_q + 2'd1, nxt_len_q[PtrW-1:0]};
              nxt_len_d = nxt_len_q + 1'b1;
            end
            default: ;
          endcase
          if (emit) begin
            ovalid_d  = 1'b1;
            olast_d   = ((emitted_q + 1'b1) == count_q);
            emitted_d = emitted_q + 1'b1;
            odata_d[7:0]   = j_rdata.name;
            odata_d[9:8]   = lvl_q;
            if (ex.act == tlfq_pkg::ACT_DONE) begin
              odata_d[31:10] = gt_new;
              odata_d[53:32] = gt_new - TW'(j_rdata.burst);
            end else begin
              odata_d[31:10] = '0;
              odata_d[53:32] = '0;
            end
            odata_d[75:54] = started_new ? first_new : '0;
            odata_d[79:76] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tlfq_pkg::ST_LOAD;
      lvl_q      <= tlfq_pkg::LvlOne;
      count_q    <= '0;
      emitted_q  <= '0;
      cur_head_q <= '0;
      cur_len_q  <= '0;
      nxt_len_q  <= '0;
      gt_q       <= '0;
      lt_q       <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      lvl_q      <= lvl_d;
      count_q    <= count_d;
      emitted_q  <= emitted_d;
      cur_head_q <= cur_head_d;
      cur_len_q  <= cur_len_d;
      nxt_len_q  <= nxt_len_d;
      gt_q       <= gt_d;
      lt_q       <= lt_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    olast_q <= olast_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire
